@@ hdl/kmpl_pkg.sv @@
package kmpl_pkg;

  localparam int KEY_W   = 32;
  localparam int COST_W  = 16;
  localparam int EST_W   = 16;
  localparam int SUM_W   = 17;
  localparam int ENTRY_W = KEY_W + COST_W + EST_W;
  localparam int STAT_W  = 3;
  localparam int TOTAL_W = 7;

  // result codes
  localparam logic [STAT_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_REJECTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  // command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [COST_W-1:0] cost;
    logic [EST_W-1:0]  est;
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic             cost_lower;
    logic [SUM_W-1:0] sum;
    logic             sum_lower;
  } cmp_t;

endpackage

@@ hdl/keyed_min_priority_list_core.sv @@
// Channel   Ports                                         Handshake
// command   command, key, cost, estimate                  start & !busy
// result    status, out_key, out_cost, out_estimate,      done (one cycle)
//           entry_total
//
// Each transaction scans the table and then, for a remove or a replacing add, shifts
// the later entries down, one table entry per cycle through the single read port of
// the entry RAM; done is registered when the walk ends.
// busy is high from acceptance until the result cycle; the result cannot be stalled.
// rst is synchronous and empties the table; RAM contents are not cleared.
module keyed_min_priority_list_core #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command,
  input  logic [kmpl_pkg::KEY_W-1:0]           key,
  input  logic [kmpl_pkg::COST_W-1:0]          cost,
  input  logic [kmpl_pkg::EST_W-1:0]           estimate,
  output logic                                 done,
  output logic [kmpl_pkg::STAT_W-1:0]          status,
  output logic [kmpl_pkg::KEY_W-1:0]           out_key,
  output logic [kmpl_pkg::COST_W-1:0]          out_cost,
  output logic [kmpl_pkg::EST_W-1:0]           out_estimate,
  output logic [kmpl_pkg::TOTAL_W-1:0]         entry_total
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t                         state;
  logic                           cmd_r;
  kmpl_pkg::entry_t               new_ent;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  raddr;
  logic                           pv;
  logic [AW-1:0]                  pidx;
  logic [AW-1:0]                  best_idx;
  logic [kmpl_pkg::SUM_W-1:0]     best_sum;
  kmpl_pkg::entry_t               best_ent;

  logic                           issue;
  logic                           walk_end;
  logic [CW-1:0]                  count_inc;
  logic [CW-1:0]                  count_dec;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  kmpl_pkg::entry_t               ram_wdata;
  kmpl_pkg::entry_t               ram_rdata;
  kmpl_pkg::cmp_t                 cmp;

  assign busy      = (state != S_IDLE);
  assign issue     = busy && (raddr < count);
  assign walk_end  = !pv && (raddr >= count);
  assign count_inc = count + CW'(1);
  assign count_dec = count - CW'(1);

  kmpl_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr[AW-1:0]),
    .rdata (ram_rdata)
  );

  kmpl_cmp u_cmp (
    .ent      (ram_rdata),
    .key      (new_ent.key),
    .cost     (new_ent.cost),
    .best_sum (best_sum),
    .res      (cmp)
  );

  // RAM write: shift moves entry down one place; append lands at the tail
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = new_ent;
    case (state)
      S_SHIFT: begin
        if (pv) begin
          ram_we    = 1'b1;
          ram_waddr = pidx - AW'(1);
          ram_wdata = ram_rdata;
        end else if (walk_end && cmd_r == kmpl_pkg::CMD_ADD) begin
          ram_we    = 1'b1;
          ram_waddr = count_dec[AW-1:0];
        end
      end
      S_SCAN: begin
        if (walk_end && cmd_r == kmpl_pkg::CMD_ADD && count < CAP_C) begin
          ram_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      raddr <= '0;
      pv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (issue) begin
        raddr <= raddr + CW'(1);
      end
      pv   <= issue;
      pidx <= raddr[AW-1:0];

      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r        <= command;
            new_ent.key  <= key;
            new_ent.cost <= cost;
            new_ent.est  <= estimate;
            raddr        <= '0;
            pv           <= 1'b0;
            state        <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (pv) begin
            if (cmd_r == kmpl_pkg::CMD_ADD) begin
              if (cmp.hit) begin
                // stop at first match; any read already in flight is dropped
                pv <= 1'b0;
                if (cmp.cost_lower) begin
                  raddr <= CW'(pidx) + CW'(1);
                  state <= S_SHIFT;
                end else begin
                  done         <= 1'b1;
                  status       <= kmpl_pkg::ST_REJECTED;
                  out_key      <= '0;
                  out_cost     <= '0;
                  out_estimate <= '0;
                  entry_total  <= kmpl_pkg::TOTAL_W'(count);
                  state        <= S_IDLE;
                end
              end
            end else if (pidx == '0 || cmp.sum_lower) begin
              // strict less-than keeps the earliest of equal priorities
              best_idx <= pidx;
              best_sum <= cmp.sum;
              best_ent <= ram_rdata;
            end
          end else if (walk_end) begin
            out_key      <= '0;
            out_cost     <= '0;
            out_estimate <= '0;
            if (cmd_r == kmpl_pkg::CMD_ADD) begin
              done  <= 1'b1;
              state <= S_IDLE;
              if (count >= CAP_C) begin
                status      <= kmpl_pkg::ST_FULL;
                entry_total <= kmpl_pkg::TOTAL_W'(count);
              end else begin
                status      <= kmpl_pkg::ST_ADDED;
                count       <= count_inc;
                entry_total <= kmpl_pkg::TOTAL_W'(count_inc);
              end
            end else if (count == '0) begin
              done        <= 1'b1;
              state       <= S_IDLE;
              status      <= kmpl_pkg::ST_EMPTY;
              entry_total <= kmpl_pkg::TOTAL_W'(count);
            end else begin
              raddr <= CW'(best_idx) + CW'(1);
              state <= S_SHIFT;
            end
          end
        end

        S_SHIFT: begin
          if (walk_end) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (cmd_r == kmpl_pkg::CMD_ADD) begin
              // old entry dropped and new one appended: count unchanged
              status       <= kmpl_pkg::ST_ADDED;
              out_key      <= '0;
              out_cost     <= '0;
              out_estimate <= '0;
              entry_total  <= kmpl_pkg::TOTAL_W'(count);
            end else begin
              status       <= kmpl_pkg::ST_REMOVED;
              out_key      <= best_ent.key;
              out_cost     <= best_ent.cost;
              out_estimate <= best_ent.est;
              count        <= count_dec;
              entry_total  <= kmpl_pkg::TOTAL_W'(count_dec);
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && status != kmpl_pkg::ST_REMOVED) |->
      (out_key == '0 && out_cost == '0 && out_estimate == '0))
    else $error("removed-entry fields not zero on non-remove result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start");
`endif

endmodule

@@ hdl/kmpl_ram.sv @@
module kmpl_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  kmpl_pkg::entry_t               wdata,
  input  logic [AW-1:0]                  raddr,
  output kmpl_pkg::entry_t               rdata
);

  kmpl_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/kmpl_cmp.sv @@
module kmpl_cmp (
  input  kmpl_pkg::entry_t                    ent,
  input  logic [kmpl_pkg::KEY_W-1:0]          key,
  input  logic [kmpl_pkg::COST_W-1:0]         cost,
  input  logic [kmpl_pkg::SUM_W-1:0]          best_sum,
  output kmpl_pkg::cmp_t                      res
);

  logic [kmpl_pkg::SUM_W-1:0] sum;

  // one 17-bit adder and the compares shared by every scan step
  assign sum = kmpl_pkg::SUM_W'(ent.cost) + kmpl_pkg::SUM_W'(ent.est);

  always_comb begin
    res.hit        = (ent.key == key);
    res.cost_lower = (cost < ent.cost);
    res.sum        = sum;
    res.sum_lower  = (sum < best_sum);
  end

endmodule
